/* design/mfe_pkg.sv */
// Shared types, codes and defaults for the mailbox FIFO endpoint.
package mfe_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int SEL_W = 3;
  localparam int THR_W = 8;
  localparam int IRQ_W = 3;
  localparam int ERR_W = 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_CPU_READ  = 2'd0,
    OP_CPU_WRITE = 2'd1,
    OP_PUSH      = 2'd2,
    OP_POP       = 2'd3
  } op_t;

  localparam logic [SEL_W-1:0] REG_WRDATA  = 3'd0;
  localparam logic [SEL_W-1:0] REG_RDDATA  = 3'd1;
  localparam logic [SEL_W-1:0] REG_STATUS  = 3'd2;
  localparam logic [SEL_W-1:0] REG_ERROR   = 3'd3;
  localparam logic [SEL_W-1:0] REG_IRQ     = 3'd4;
  localparam logic [SEL_W-1:0] REG_CONTROL = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SEND_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_EN   = 2'd2;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

/* design/mfe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mfe_ctrl.sv */
// Controller state machine that sequences one transaction through the datapath.
module mfe_ctrl import mfe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.execute;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ST_IDLE: cmd.capture = start;
      ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

/* design/mfe_datapath.sv */
// Datapath with both FIFOs, error and interrupt state, and the register file.
module mfe_datapath import mfe_pkg::*; #(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
  parameter int LVL_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  input  logic [1:0]           opcode,
  input  logic [SEL_W-1:0]     reg_select,
  input  logic [DATA_W-1:0]    write_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  output logic [DATA_W-1:0]    read_data,
  output logic [DATA_W-1:0]    pop_data,
  output logic                 pop_valid,
  output logic                 irq_line,
  output logic [LVL_W-1:0]     tx_fill,
  output logic [LVL_W-1:0]     rx_fill
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CMP_W = (LVL_W > THR_W) ? LVL_W : THR_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(FIFO_DEPTH);

  op_t              op;
  logic [SEL_W-1:0]  sel;
  logic [DATA_W-1:0] data;

  logic [THR_W-1:0] send_threshold;
  logic [THR_W-1:0] receive_threshold;
  logic [IRQ_W-1:0] irq_enable;

  logic [PTR_W-1:0] tx_rptr, tx_wptr, rx_rptr, rx_wptr;
  logic [PTR_W-1:0] tx_rptr_next, tx_wptr_next, rx_rptr_next, rx_wptr_next;
  logic [LVL_W-1:0] tx_level, rx_level, tx_level_next, rx_level_next;
  logic [ERR_W-1:0] error_flags, error_flags_next;
  logic [IRQ_W-1:0] irq_pending, irq_pending_next, irq_kept, irq_cond;

  logic [DATA_W-1:0] read_data_next, pop_data_next;
  logic              pop_valid_next;
  logic              tx_we, rx_we;
  logic [DATA_W-1:0] tx_rdata, rx_rdata;
  logic [3:0]        status;

  mfe_ram #(.WIDTH(DATA_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wptr),
    .wdata (data),
    .raddr (tx_rptr),
    .rdata (tx_rdata)
  );

  mfe_ram #(.WIDTH(DATA_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wptr),
    .wdata (data),
    .raddr (rx_rptr),
    .rdata (rx_rdata)
  );

  assign status = {
    CMP_W'(rx_level) > CMP_W'(receive_threshold),
    CMP_W'(tx_level) <= CMP_W'(send_threshold),
    rx_level == '0,
    tx_level == LVL_FULL
  };

  always_comb begin
    tx_rptr_next     = tx_rptr;
    tx_wptr_next     = tx_wptr;
    rx_rptr_next     = rx_rptr;
    rx_wptr_next     = rx_wptr;
    tx_level_next    = tx_level;
    rx_level_next    = rx_level;
    error_flags_next = error_flags;
    irq_kept         = irq_pending;
    read_data_next   = '0;
    pop_data_next    = '0;
    pop_valid_next   = 1'b0;
    tx_we            = 1'b0;
    rx_we            = 1'b0;
    unique case (op)
      OP_CPU_READ: begin
        case (sel)
          REG_RDDATA: begin
            if (rx_level == '0) begin
              error_flags_next[0] = 1'b1;
            end else begin
              read_data_next = rx_rdata;
              rx_rptr_next   = (rx_rptr == PTR_LAST) ? '0 : rx_rptr + PTR_W'(1);
              rx_level_next  = rx_level - LVL_W'(1);
            end
          end
          REG_STATUS: read_data_next = DATA_W'(status);
          REG_ERROR:  read_data_next = DATA_W'(error_flags);
          REG_IRQ:    read_data_next = DATA_W'(irq_pending);
          default:    read_data_next = '0;
        endcase
      end
      OP_CPU_WRITE: begin
        case (sel)
          REG_WRDATA: begin
            if (tx_level == LVL_FULL) begin
              error_flags_next[1] = 1'b1;
            end else begin
              tx_we         = cmd.execute;
              tx_wptr_next  = (tx_wptr == PTR_LAST) ? '0 : tx_wptr + PTR_W'(1);
              tx_level_next = tx_level + LVL_W'(1);
            end
          end
          REG_IRQ: irq_kept = irq_pending & ~data[IRQ_W-1:0];
          REG_CONTROL: begin
            tx_rptr_next     = '0;
            tx_wptr_next     = '0;
            rx_rptr_next     = '0;
            rx_wptr_next     = '0;
            tx_level_next    = '0;
            rx_level_next    = '0;
            error_flags_next = '0;
          end
          default: irq_kept = irq_pending;
        endcase
      end
      OP_PUSH: begin
        if (rx_level != LVL_FULL) begin
          rx_we         = cmd.execute;
          rx_wptr_next  = (rx_wptr == PTR_LAST) ? '0 : rx_wptr + PTR_W'(1);
          rx_level_next = rx_level + LVL_W'(1);
        end
      end
      OP_POP: begin
        if (tx_level != '0) begin
          pop_data_next  = tx_rdata;
          pop_valid_next = 1'b1;
          tx_rptr_next   = (tx_rptr == PTR_LAST) ? '0 : tx_rptr + PTR_W'(1);
          tx_level_next  = tx_level - LVL_W'(1);
        end
      end
      default: pop_valid_next = 1'b0;
    endcase

    irq_cond = {
      CMP_W'(tx_level_next) <= CMP_W'(send_threshold),
      CMP_W'(rx_level_next) > CMP_W'(receive_threshold),
      error_flags_next != '0
    };
    irq_pending_next = irq_kept | irq_cond;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= op_t'(opcode);
      sel  <= reg_select;
      data <= write_data;
    end
    if (cmd.execute) begin
      read_data <= read_data_next;
      pop_data  <= pop_data_next;
      pop_valid <= pop_valid_next;
      irq_line  <= (irq_pending_next & irq_enable) != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_threshold    <= '0;
      receive_threshold <= '0;
      irq_enable        <= '0;
      tx_rptr           <= '0;
      tx_wptr           <= '0;
      rx_rptr           <= '0;
      rx_wptr           <= '0;
      tx_level          <= '0;
      rx_level          <= '0;
      error_flags       <= '0;
      irq_pending       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEND_THR: send_threshold    <= cfg_data;
          CFG_RECV_THR: receive_threshold <= cfg_data;
          CFG_IRQ_EN:   irq_enable        <= cfg_data[IRQ_W-1:0];
          default:      irq_enable        <= irq_enable;
        endcase
      end
      if (cmd.execute) begin
        tx_rptr     <= tx_rptr_next;
        tx_wptr     <= tx_wptr_next;
        rx_rptr     <= rx_rptr_next;
        rx_wptr     <= rx_wptr_next;
        tx_level    <= tx_level_next;
        rx_level    <= rx_level_next;
        error_flags <= error_flags_next;
        irq_pending <= irq_pending_next;
      end
    end
  end

  assign tx_fill = tx_level;
  assign rx_fill = rx_level;

endmodule

/* design/mailbox_fifo_endpoint_core.sv */
// Top level of the mailbox FIFO endpoint: controller plus datapath.
//
//   channel   handshake          payload
//   command   start / busy       opcode, reg_select, write_data
//   result    done (strobe)      read_data, pop_data, pop_valid, irq_line, tx_fill, rx_fill
//   config    cfg_we             cfg_index, cfg_data
//
// Each transaction is captured in the idle state and applied in the execute state:
// the capture edge starts the FIFO RAM read, and the execute state applies the
// update with the registered RAM data. The result is shown with done in the cycle
// after, when start is taken again; a new transaction is not taken while busy is high.
// Reset is synchronous; it empties both FIFOs and clears errors, interrupts
// and configuration. The result side has no back-pressure.
module mailbox_fifo_endpoint_core import mfe_pkg::*; #(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
  parameter int LVL_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [SEL_W-1:0]     reg_select,
  input  logic [DATA_W-1:0]    write_data,
  output logic                 done,
  output logic [DATA_W-1:0]    read_data,
  output logic [DATA_W-1:0]    pop_data,
  output logic                 pop_valid,
  output logic                 irq_line,
  output logic [LVL_W-1:0]     tx_fill,
  output logic [LVL_W-1:0]     rx_fill,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  ctrl_cmd_t cmd;

  mfe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  mfe_datapath #(.FIFO_DEPTH(FIFO_DEPTH), .LVL_W(LVL_W)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .opcode     (opcode),
    .reg_select (reg_select),
    .write_data (write_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .read_data  (read_data),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .irq_line   (irq_line),
    .tx_fill    (tx_fill),
    .rx_fill    (rx_fill)
  );

endmodule

/* design/mfe_checker.sv */
// Port-level checks for the mailbox FIFO endpoint, bound to the top level.
module mfe_checker import mfe_pkg::*; #(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
  parameter int LVL_W = $clog2(FIFO_DEPTH + 1)
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [DATA_W-1:0] pop_data,
  input logic              pop_valid,
  input logic [LVL_W-1:0]  tx_fill,
  input logic [LVL_W-1:0]  rx_fill
);

  // Every result follows the transaction that was taken, after its execute state.
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction taken but block not busy");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_pop_data_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !pop_valid) |-> (pop_data == '0))
    else $error("pop data nonzero without a popped word");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (tx_fill <= LVL_W'(FIFO_DEPTH)) && (rx_fill <= LVL_W'(FIFO_DEPTH)))
    else $error("FIFO level beyond depth");

endmodule

bind mailbox_fifo_endpoint_core mfe_checker #(
  .FIFO_DEPTH (FIFO_DEPTH),
  .LVL_W      (LVL_W)
) u_mfe_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .pop_data  (pop_data),
  .pop_valid (pop_valid),
  .tx_fill   (tx_fill),
  .rx_fill   (rx_fill)
);

/* sim/tb_top.sv */
// Self-checking testbench for the mailbox FIFO endpoint core, driven by transactions.
`timescale 1ns / 100ps
module tb_top;
  import mfe_pkg::*;

  localparam int DEPTH = DEFAULT_FIFO_DEPTH;
  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 96;
  localparam int NUM_ROWS = 36;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int STAT_TX_FULL = 0;
  localparam int STAT_RX_EMPTY = 1;
  localparam int STAT_SEND = 2;
  localparam int STAT_RECV = 3;
  localparam int ERR_EMPTY = 0;
  localparam int ERR_FULL = 1;
  localparam int IRQ_ERR = 0;
  localparam int IRQ_RECV = 1;
  localparam int IRQ_SEND = 2;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] popped;
    logic              valid;
    logic              irq;
    logic [LVL_W-1:0]  tx;
    logic [LVL_W-1:0]  rx;
  } mbox_result_t;

  typedef struct packed {
    op_t               op;
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] data;
    logic [7:0]        reps;
    logic              typed;
    mbox_result_t      res;
  } access_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           opcode = '0;
  logic [SEL_W-1:0]     reg_select = '0;
  logic [DATA_W-1:0]    write_data = '0;
  logic                 done;
  logic [DATA_W-1:0]    read_data;
  logic [DATA_W-1:0]    pop_data;
  logic                 pop_valid;
  logic                 irq_line;
  logic [LVL_W-1:0]     tx_fill;
  logic [LVL_W-1:0]     rx_fill;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data = '0;

  logic [DATA_W-1:0] tx_mem [DEPTH];
  logic [DATA_W-1:0] rx_mem [DEPTH];
  int unsigned       tx_head = 0;
  int unsigned       tx_count = 0;
  int unsigned       rx_head = 0;
  int unsigned       rx_count = 0;
  logic [ERR_W-1:0]  err_flags = '0;
  logic [IRQ_W-1:0]  irq_pend = '0;
  logic [THR_W-1:0]  send_thr = '0;
  logic [THR_W-1:0]  recv_thr = '0;
  logic [IRQ_W-1:0]  irq_en = '0;

  mbox_result_t awaited_results [$];
  int unsigned  error_count = 0;
  int unsigned  issued_count = 0;
  int unsigned  idle_pct = 0;
  int unsigned  quiet_cycles = 0;

  // Rows with a repeat count above one use fresh random data for every transaction.
  access_row_t dir_rows [NUM_ROWS] = '{
    '{OP_CPU_READ,  REG_STATUS,  32'h0,        8'd1,  1'b1, '{32'h6, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}},
    '{OP_CPU_READ,  REG_IRQ,     32'h0,        8'd1,  1'b1, '{32'h4, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}},
    '{OP_CPU_READ,  REG_ERROR,   32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}},
    '{OP_CPU_READ,  REG_RDDATA,  32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}},
    '{OP_CPU_READ,  REG_ERROR,   32'h0,        8'd1,  1'b1, '{32'h1, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}},
    '{OP_POP,       3'd7,        32'hFFFFFFFF, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}},
    '{OP_CPU_WRITE, REG_WRDATA,  32'hFFFFFFFF, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_WRITE, REG_WRDATA,  32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd2, 5'd0}},
    '{OP_POP,       REG_WRDATA,  32'h0,        8'd1,  1'b1,
      '{32'h0, 32'hFFFFFFFF, 1'b1, 1'b0, 5'd1, 5'd0}},
    '{OP_PUSH,      REG_CONTROL, 32'hA5A5A5A5, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd1}},
    '{OP_CPU_READ,  REG_STATUS,  32'h0,        8'd1,  1'b1, '{32'h8, 32'h0, 1'b0, 1'b0, 5'd1, 5'd1}},
    '{OP_CPU_READ,  REG_RDDATA,  32'h0,        8'd1,  1'b1,
      '{32'hA5A5A5A5, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_READ,  REG_WRDATA,  32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_READ,  REG_CONTROL, 32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_READ,  3'd6,        32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_READ,  3'd7,        32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_WRITE, REG_STATUS,  32'hFFFFFFFF, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_WRITE, REG_ERROR,   32'hFFFFFFFF, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_WRITE, REG_RDDATA,  32'hFFFFFFFF, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_WRITE, 3'd6,        32'hFFFFFFFF, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_WRITE, 3'd7,        32'hFFFFFFFF, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_WRITE, REG_IRQ,     32'hFFFFFFFF, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_READ,  REG_IRQ,     32'h0,        8'd1,  1'b1, '{32'h1, 32'h0, 1'b0, 1'b0, 5'd1, 5'd0}},
    '{OP_CPU_WRITE, REG_CONTROL, 32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}},
    '{OP_CPU_READ,  REG_ERROR,   32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}},
    '{OP_CPU_WRITE, REG_WRDATA,  32'h0,        8'd16, 1'b0, '0},
    '{OP_CPU_WRITE, REG_WRDATA,  32'h12345678, 8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd16, 5'd0}},
    '{OP_CPU_READ,  REG_STATUS,  32'h0,        8'd1,  1'b1, '{32'h3, 32'h0, 1'b0, 1'b0, 5'd16, 5'd0}},
    '{OP_CPU_READ,  REG_ERROR,   32'h0,        8'd1,  1'b1, '{32'h2, 32'h0, 1'b0, 1'b0, 5'd16, 5'd0}},
    '{OP_PUSH,      REG_WRDATA,  32'h0,        8'd16, 1'b0, '0},
    '{OP_PUSH,      REG_STATUS,  32'h0,        8'd1,  1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 5'd16, 5'd16}},
    '{OP_CPU_READ,  REG_STATUS,  32'h0,        8'd1,  1'b1, '{32'h9, 32'h0, 1'b0, 1'b0, 5'd16, 5'd16}},
    '{OP_POP,       REG_IRQ,     32'h0,        8'd16, 1'b0, '0},
    '{OP_CPU_READ,  REG_RDDATA,  32'h0,        8'd16, 1'b0, '0},
    '{OP_CPU_READ,  REG_STATUS,  32'h0,        8'd1,  1'b1, '{32'h6, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}},
    '{OP_CPU_READ,  REG_ERROR,   32'h0,        8'd1,  1'b1, '{32'h2, 32'h0, 1'b0, 1'b0, 5'd0, 5'd0}}
  };

  mailbox_fifo_endpoint_core uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .reg_select (reg_select),
    .write_data (write_data),
    .done       (done),
    .read_data  (read_data),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .irq_line   (irq_line),
    .tx_fill    (tx_fill),
    .rx_fill    (rx_fill),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] mailbox_status();
    logic [3:0] s;
    s = '0;
    s[STAT_TX_FULL] = (tx_count >= DEPTH);
    s[STAT_RX_EMPTY] = (rx_count == 0);
    s[STAT_SEND] = (tx_count <= send_thr);
    s[STAT_RECV] = (rx_count > recv_thr);
    return s;
  endfunction

  function automatic mbox_result_t predict_access(op_t op, logic [SEL_W-1:0] sel,
                                                  logic [DATA_W-1:0] data);
    mbox_result_t r;
    logic [3:0] st;
    logic [IRQ_W-1:0] cond;
    r = '0;
    case (op)
      OP_CPU_READ: begin
        if (sel == REG_RDDATA) begin
          if (rx_count == 0) begin
            err_flags[ERR_EMPTY] = 1'b1;
          end else begin
            r.rd = rx_mem[rx_head];
            rx_head = (rx_head + 1) % DEPTH;
            rx_count--;
          end
        end else if (sel == REG_STATUS) begin
          r.rd = DATA_W'(mailbox_status());
        end else if (sel == REG_ERROR) begin
          r.rd = DATA_W'(err_flags);
        end else if (sel == REG_IRQ) begin
          r.rd = DATA_W'(irq_pend);
        end
      end
      OP_CPU_WRITE: begin
        if (sel == REG_WRDATA) begin
          if (tx_count >= DEPTH) begin
            err_flags[ERR_FULL] = 1'b1;
          end else begin
            tx_mem[(tx_head + tx_count) % DEPTH] = data;
            tx_count++;
          end
        end else if (sel == REG_IRQ) begin
          irq_pend = irq_pend & ~data[IRQ_W-1:0];
        end else if (sel == REG_CONTROL) begin
          tx_head = 0;
          tx_count = 0;
          rx_head = 0;
          rx_count = 0;
          err_flags = '0;
        end
      end
      OP_PUSH: begin
        if (rx_count < DEPTH) begin
          rx_mem[(rx_head + rx_count) % DEPTH] = data;
          rx_count++;
        end
      end
      default: begin
        if (tx_count != 0) begin
          r.popped = tx_mem[tx_head];
          r.valid = 1'b1;
          tx_head = (tx_head + 1) % DEPTH;
          tx_count--;
        end
      end
    endcase
    // Interrupt bits are set by level once the access has taken effect.
    st = mailbox_status();
    cond = '0;
    cond[IRQ_ERR] = |err_flags;
    cond[IRQ_RECV] = st[STAT_RECV];
    cond[IRQ_SEND] = st[STAT_SEND];
    irq_pend = irq_pend | cond;
    r.irq = |(irq_pend & irq_en);
    r.tx = LVL_W'(tx_count);
    r.rx = LVL_W'(rx_count);
    return r;
  endfunction

  task automatic issue(op_t op, logic [SEL_W-1:0] sel, logic [DATA_W-1:0] data,
                       logic typed, mbox_result_t typed_res);
    mbox_result_t predicted;
    start <= 1'b1;
    opcode <= op;
    reg_select <= sel;
    write_data <= data;
    do @(posedge clk); while (busy);
    predicted = predict_access(op, sel, data);
    awaited_results.push_back(typed ? typed_res : predicted);
    issued_count++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SEND_THR: send_thr = val;
      CFG_RECV_THR: recv_thr = val;
      CFG_IRQ_EN: irq_en = val[IRQ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [THR_W-1:0] s_thr, logic [THR_W-1:0] r_thr,
                           logic [THR_W-1:0] en);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_cfg(CFG_SEND_THR, s_thr);
    write_cfg(CFG_RECV_THR, r_thr);
    write_cfg(CFG_IRQ_EN, en);
    write_cfg(CFG_UNUSED, THR_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  // A burst mostly fills or drains one FIFO or exercises the register file, with
  // some fully random transactions mixed in, or is made of random transactions only.
  task automatic random_burst();
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    op_t op;
    logic [SEL_W-1:0] sel;
    logic [DATA_W-1:0] data;
    kind = $urandom_range(5);
    len = $urandom_range(1, 20);
    repeat (len) begin
      pick = $urandom_range(9);
      data = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
      sel = SEL_W'($urandom_range(7));
      if (kind == 4 || $urandom_range(99) < 15) begin
        op = op_t'($urandom_range(3));
      end else begin
        case (kind)
          0: begin
            op = OP_CPU_WRITE;
            sel = REG_WRDATA;
          end
          1: op = OP_POP;
          2: op = OP_PUSH;
          3: begin
            op = OP_CPU_READ;
            sel = REG_RDDATA;
          end
          default: begin
            pick = $urandom_range(19);
            op = (pick < 5) ? OP_CPU_WRITE : OP_CPU_READ;
            sel = (pick == 0) ? REG_CONTROL : (pick < 5) ? REG_IRQ :
                  SEL_W'($urandom_range(REG_STATUS, REG_IRQ));
          end
        endcase
      end
      issue(op, sel, data, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    mbox_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $error("result with no transaction outstanding");
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (read_data !== want.rd) begin
          $error("read_data: expected %h, got %h", want.rd, read_data);
          error_count++;
        end
        if (pop_data !== want.popped) begin
          $error("pop_data: expected %h, got %h", want.popped, pop_data);
          error_count++;
        end
        if (pop_valid !== want.valid) begin
          $error("pop_valid: expected %b, got %b", want.valid, pop_valid);
          error_count++;
        end
        if (irq_line !== want.irq) begin
          $error("irq_line: expected %b, got %b", want.irq, irq_line);
          error_count++;
        end
        if (tx_fill !== want.tx) begin
          $error("tx_fill: expected %0d, got %0d", want.tx, tx_fill);
          error_count++;
        end
        if (rx_fill !== want.rx) begin
          $error("rx_fill: expected %0d, got %0d", want.rx, rx_fill);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 26;
    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        issue(dir_rows[i].op, dir_rows[i].sel,
              (dir_rows[i].reps > 1) ? $urandom() : dir_rows[i].data,
              dir_rows[i].typed, dir_rows[i].res);
      end
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: configure(8'd255, 8'd255, 8'd7);
        1: configure(8'd0, 8'd0, 8'hFF);
        2: configure(8'd4, 8'd12, 8'd1);
        3: configure(8'd16, 8'd15, 8'd2);
        4: configure(THR_W'($urandom_range(17)), THR_W'($urandom_range(17)), 8'd4);
        default: configure(THR_W'($urandom()), THR_W'($urandom_range(17)), THR_W'($urandom()));
      endcase
      idle_pct = (p < 2) ? 26 : (p < 4) ? 64 : 0;
      target = issued_count + ITEMS_PER_PHASE;
      while (issued_count < target) random_burst();
    end
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
design/mfe_pkg.sv
design/mfe_ram.sv
design/mfe_ctrl.sv
design/mfe_datapath.sv
design/mailbox_fifo_endpoint_core.sv
design/mfe_checker.sv
sim/tb_top.sv
